[rtl/msat_pkg.sv]
// Shared constants, types and helpers for the mean HSV saturation block.
package msat_pkg;

   // Pixel counter width; the sum is held exactly at COUNT_BITS + 16 bits.
   localparam int COUNT_BITS   = 24;
   localparam int PIX_BITS     = 8;
   localparam int QUO_BITS     = 16;
   localparam int SUM_BITS     = COUNT_BITS + QUO_BITS;
   // Mean dividend is 2*sum + n, always below 2n * 2^16.
   localparam int DVD_BITS     = COUNT_BITS + QUO_BITS + 1;
   localparam int DVS_BITS     = DVD_BITS - QUO_BITS;
   localparam int STEP_BITS    = $clog2(QUO_BITS);
   localparam int TOTAL_BITS   = 24;
   // Pixel dividend is 131070*d + mx, below 2^25.
   localparam int PIX_NUM_BITS = 25;
   localparam int SAT_TWICE    = 131070;

   typedef struct packed {
      logic                start;
      logic [DVD_BITS-1:0] dividend;
      logic [DVS_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } div_rsp_type;

   // Pixel count as reported, saturating when the counter is wider.
   function automatic logic [TOTAL_BITS-1:0] total_clip(input logic [COUNT_BITS-1:0] cnt);
      logic [COUNT_BITS-1:0] upper;
      upper = cnt >> TOTAL_BITS;
      if (upper != '0) begin
         total_clip = '1;
      end else begin
         total_clip = TOTAL_BITS'(cnt);
      end
   endfunction

endpackage

[rtl/msat_div.sv]
// Shared restoring divider: 16 quotient bits, one bit per cycle.
module msat_div (
   input  logic                  clock,
   input  logic                  reset,
   input  msat_pkg::div_req_type div_req,
   output msat_pkg::div_rsp_type div_rsp
);

   localparam logic [msat_pkg::STEP_BITS-1:0] STEP_LAST =
      msat_pkg::STEP_BITS'(msat_pkg::QUO_BITS - 1);

   logic [msat_pkg::DVS_BITS-1:0]  rem_ff, rem_in;
   logic [msat_pkg::DVS_BITS-1:0]  dvs_ff, dvs_in;
   logic [msat_pkg::QUO_BITS-1:0]  quo_ff, quo_in;
   logic [msat_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [msat_pkg::DVS_BITS:0]    trial;
   logic [msat_pkg::DVS_BITS:0]    diff;
   logic                           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[msat_pkg::QUO_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         // remainder seeds with the upper dividend bits, below any nonzero divisor
         rem_in  = div_req.dividend[msat_pkg::DVD_BITS-1:msat_pkg::QUO_BITS];
         quo_in  = div_req.dividend[msat_pkg::QUO_BITS-1:0];
         dvs_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[msat_pkg::DVS_BITS-1:0] : trial[msat_pkg::DVS_BITS-1:0];
         quo_in  = {quo_ff[msat_pkg::QUO_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/mean_hsv_saturation.sv]
// Top level: mean HSV saturation of an RGB pixel stream.
//
// Input channel (req_*): one RGB pixel per transaction, 8 bits per channel,
// with an image tag and a last-pixel mark. Result channel (rsp_*): one
// transaction per image, sent after its last pixel, carrying the tag, the
// rounded mean saturation (0.16 fraction), the pixel count and an overflow flag.
// Each pixel, once accepted, has its ratio operands formed and the ratio
// launched in the shared one-bit-per-cycle divider; after the division it is
// accumulated and req_ready returns. A last pixel then runs the mean division
// (launch, divider steps, done) and loads the output register once that is
// free, so its result can also wait on rsp_ready.
// The output register decouples the sides: a new image is accepted while the
// previous result waits; only the next result load waits for rsp_ready.
// Synchronous reset clears the sequencer, accumulators and rsp_valid.
// A pixel arriving with the counter full is dropped from the mean, skips the
// pixel division and sets the overflow flag.
module mean_hsv_saturation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_image_index,
   input  logic [msat_pkg::PIX_BITS-1:0]   req_red,
   input  logic [msat_pkg::PIX_BITS-1:0]   req_green,
   input  logic [msat_pkg::PIX_BITS-1:0]   req_blue,
   input  logic                            req_last_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_image_tag,
   output logic [msat_pkg::QUO_BITS-1:0]   rsp_mean_saturation,
   output logic [msat_pkg::TOTAL_BITS-1:0] rsp_pixel_total,
   output logic                            rsp_overflow
);

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,  // waiting for a pixel
      S_PREP   = 6'b000010,  // launch pixel ratio division, or drop the pixel
      S_PDIV   = 6'b000100,  // pixel ratio in progress
      S_MSTART = 6'b001000,  // launch mean division
      S_MDIV   = 6'b010000,  // mean division in progress
      S_OUT    = 6'b100000   // load result register
   } state_type;

   state_type state_ff, state_in;

   // Captured pixel
   logic [msat_pkg::PIX_BITS-1:0]   mx_ff, mx_in;
   logic [msat_pkg::PIX_BITS-1:0]   dlt_ff, dlt_in;
   logic                            tag_ff, tag_in;
   logic                            last_ff, last_in;

   // Accumulators
   logic [msat_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   logic [msat_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                            ovf_ff, ovf_in;

   // Result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_tag_ff, rsp_tag_in;
   logic [msat_pkg::QUO_BITS-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [msat_pkg::TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   logic [msat_pkg::PIX_BITS-1:0]     ch_max, ch_min;
   logic [msat_pkg::PIX_NUM_BITS-1:0] pix_num;
   logic                              cnt_full;
   logic                              accept;
   logic                              out_free;

   msat_pkg::div_req_type div_req;
   msat_pkg::div_rsp_type div_rsp;

   msat_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign cnt_full  = (cnt_ff == '1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Channel max/min of the incoming pixel
   always_comb begin
      ch_max = req_red;
      ch_min = req_red;
      if (req_green > ch_max) ch_max = req_green;
      if (req_blue  > ch_max) ch_max = req_blue;
      if (req_green < ch_min) ch_min = req_green;
      if (req_blue  < ch_min) ch_min = req_blue;
   end

   // round(65535*d/mx) = floor((131070*d + mx) / (2*mx)); black gives 0 / 0
   // which the divider returns as all ones, so black is forced below
   assign pix_num = msat_pkg::PIX_NUM_BITS'(msat_pkg::SAT_TWICE)
                    * msat_pkg::PIX_NUM_BITS'(dlt_ff)
                    + msat_pkg::PIX_NUM_BITS'(mx_ff);

   always_comb begin
      state_in     = state_ff;
      mx_in        = mx_ff;
      dlt_in       = dlt_ff;
      tag_in       = tag_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      div_req.start    = 1'b0;
      div_req.dividend = msat_pkg::DVD_BITS'(pix_num);
      div_req.divisor  = msat_pkg::DVS_BITS'({mx_ff, 1'b0});

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mx_in    = ch_max;
               dlt_in   = ch_max - ch_min;
               tag_in   = req_image_index;
               last_in  = req_last_pixel;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (cnt_full) begin
               // counter full: pixel dropped, flag it
               ovf_in   = 1'b1;
               state_in = last_ff ? S_MSTART : S_IDLE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_PDIV;
            end
         end
         S_PDIV: begin
            if (div_rsp.done) begin
               if (mx_ff != '0) begin
                  sum_in = sum_ff + msat_pkg::SUM_BITS'(div_rsp.quotient);
               end
               cnt_in   = cnt_ff + 1'b1;
               state_in = last_ff ? S_MSTART : S_IDLE;
            end
         end
         S_MSTART: begin
            // mean = floor((2*sum + n) / (2*n)); n >= 1 here
            div_req.start    = 1'b1;
            div_req.dividend = {sum_ff, 1'b0} + msat_pkg::DVD_BITS'(cnt_ff);
            div_req.divisor  = {cnt_ff, 1'b0};
            state_in         = S_MDIV;
         end
         S_MDIV: begin
            if (div_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // quotient holds in the divider until the result register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = tag_ff;
               rsp_mean_in  = div_rsp.quotient;
               rsp_total_in = msat_pkg::total_clip(cnt_ff);
               rsp_ovf_in   = ovf_ff;
               sum_in       = '0;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mx_ff        <= mx_in;
      dlt_ff       <= dlt_in;
      tag_ff       <= tag_in;
      last_ff      <= last_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_image_tag       = rsp_tag_ff;
   assign rsp_mean_saturation = rsp_mean_ff;
   assign rsp_pixel_total     = rsp_total_ff;
   assign rsp_overflow        = rsp_ovf_ff;

`ifndef SYNTHESIS
   // divider only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_PDIV || state_ff == S_MDIV))
      else $error("divider done outside a wait state");

   // accumulators are empty right after a result is loaded
   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (cnt_ff == '0 && sum_ff == '0 && rsp_valid_ff))
      else $error("accumulators not cleared after result load");

   // mean division never starts on an empty count
   a_mean_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MSTART) |-> (cnt_ff != '0))
      else $error("mean division with zero pixel count");

   // a result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_mean_ff)))
      else $error("pending result overwritten");
`endif

endmodule

[sim/mean_hsv_saturation_tb.sv]
// Testbench for mean_hsv_saturation: RGB pixel stream in, per-image mean saturation out.
module mean_hsv_saturation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msat_pkg::*;

   // Run limit in clock cycles.
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PIXEL_GOAL  = 700;
   localparam longint      SAT_MAX     = 65535;
   localparam longint      TOTAL_MAX   = (64'd1 << TOTAL_BITS) - 1;

   // One pixel transaction on the request side.
   typedef struct {
      logic                tag;
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic                last;
   } pixel_t;

   // One image summary on the response side.
   typedef struct {
      logic                  tag;
      logic [QUO_BITS-1:0]   mean;
      logic [TOTAL_BITS-1:0] total;
      logic                  ovf;
   } summary_t;

   // Tracks the running image statistics and holds the summaries still owed.
   class saturation_scoreboard;
      logic [SUM_BITS-1:0]   sat_sum;
      logic [COUNT_BITS-1:0] pix_count;
      logic                  cnt_full;
      summary_t              owed[$];
      int                    errors;

      function new();
         sat_sum   = '0;
         pix_count = '0;
         cnt_full  = 1'b0;
         errors    = 0;
      endfunction

      // Per-pixel HSV saturation, 0.16 fraction, round half up; black gives 0.
      function longint unsigned hsv_sat(pixel_t p);
         longint unsigned hi, lo;
         hi = 64'(p.red);
         lo = 64'(p.red);
         if (p.green > hi) hi = 64'(p.green);
         if (p.blue > hi) hi = 64'(p.blue);
         if (p.green < lo) lo = 64'(p.green);
         if (p.blue < lo) lo = 64'(p.blue);
         if (hi == 0) return 0;
         return (SAT_TWICE * (hi - lo) + hi) / (2 * hi);
      endfunction

      function void note_pixel(pixel_t p);
         summary_t        s;
         longint unsigned n, m;
         // Counter full: pixel dropped from the mean, flag set.
         if (pix_count == '1) begin
            cnt_full = 1'b1;
         end else begin
            sat_sum   = sat_sum + SUM_BITS'(hsv_sat(p));
            pix_count = pix_count + 1'b1;
         end
         if (!p.last) return;
         n = 64'(pix_count);
         m = (n == 0) ? 0 : (2 * longint'(sat_sum) + n) / (2 * n);
         if (m > SAT_MAX) m = SAT_MAX;
         s.tag   = p.tag;
         s.mean  = QUO_BITS'(m);
         s.total = (n > TOTAL_MAX) ? '1 : TOTAL_BITS'(n);
         s.ovf   = cnt_full;
         owed.push_back(s);
         sat_sum   = '0;
         pix_count = '0;
         cnt_full  = 1'b0;
      endfunction

      function void check_result(summary_t got);
         summary_t want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result tag=%0d mean=%0d total=%0d ovf=%0d",
                     $time, got.tag, got.mean, got.total, got.ovf);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.tag !== want.tag) begin
            $display("%0t: image_tag expected %0d actual %0d", $time, want.tag, got.tag);
            errors++;
         end
         if (got.mean !== want.mean) begin
            $display("%0t: mean_saturation expected %0d actual %0d",
                     $time, want.mean, got.mean);
            errors++;
         end
         if (got.total !== want.total) begin
            $display("%0t: pixel_total expected %0d actual %0d",
                     $time, want.total, got.total);
            errors++;
         end
         if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, got.ovf);
            errors++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_image_index = 1'b0;
   logic [PIX_BITS-1:0]   req_red = '0;
   logic [PIX_BITS-1:0]   req_green = '0;
   logic [PIX_BITS-1:0]   req_blue = '0;
   logic                  req_last_pixel = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_image_tag;
   logic [QUO_BITS-1:0]   rsp_mean_saturation;
   logic [TOTAL_BITS-1:0] rsp_pixel_total;
   logic                  rsp_overflow;

   saturation_scoreboard  sb = new();
   int                    cycle_count = 0;

   mean_hsv_saturation u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_image_index     (req_image_index),
      .req_red             (req_red),
      .req_green           (req_green),
      .req_blue            (req_blue),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_image_tag       (rsp_image_tag),
      .rsp_mean_saturation (rsp_mean_saturation),
      .rsp_pixel_total     (rsp_pixel_total),
      .rsp_overflow        (rsp_overflow)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hang or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mean_hsv_saturation_tb NOT OK");
         $finish;
      end
   end

   // Result side. Stall pattern switches mode every so often:
   //   0 - always ready (no back-pressure stretch)
   //   1 - coin flip each cycle
   //   2 - long stalls with short ready windows
   int rx_mode = 0;
   int rx_hold = 0;
   int rx_phase = 0;

   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_mode  <= $urandom_range(0, 2);
         rx_phase <= $urandom_range(60, 300);
      end else begin
         rx_phase <= rx_phase - 1;
      end
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
      end else begin
         case (rx_mode)
            0: begin
               rsp_ready <= 1'b1;
               rx_hold   <= 0;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
               rx_hold   <= 0;
            end
            default: begin
               // alternate a long low stretch with a short high one
               rsp_ready <= !rsp_ready;
               rx_hold   <= rsp_ready ? $urandom_range(5, 40) : $urandom_range(0, 2);
            end
         endcase
      end
   end

   // Sample at the rising edge; a handshake here is one result transaction.
   always @(posedge clock) begin
      summary_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.tag   = rsp_image_tag;
         got.mean  = rsp_mean_saturation;
         got.total = rsp_pixel_total;
         got.ovf   = rsp_overflow;
         sb.check_result(got);
      end
   end

   // Present one pixel from the falling edge and hold it until accepted.
   task automatic send_pixel(input pixel_t p);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_image_index <= p.tag;
      req_red         <= p.red;
      req_green       <= p.green;
      req_blue        <= p.blue;
      req_last_pixel  <= p.last;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(p);
   endtask

   // Drop valid for a gap of the given number of cycles.
   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   function automatic pixel_t make_pixel(logic tag, int r, int g, int b, logic last);
      pixel_t p;
      p.tag   = tag;
      p.red   = PIX_BITS'(r);
      p.green = PIX_BITS'(g);
      p.blue  = PIX_BITS'(b);
      p.last  = last;
      return p;
   endfunction

   // Random channel, biased now and then toward the extremes.
   function automatic int rand_chan();
      int picks[4] = '{0, 255, 1, 254};
      if ($urandom_range(0, 4) == 0) return picks[$urandom_range(0, 3)];
      return $urandom_range(0, 255);
   endfunction

   pixel_t directed_px[$];

   initial begin
      pixel_t p;
      int     sent;
      int     img_len;
      int     burst_left;
      bit     eager;

      // Directed images: black, white, pure primaries, rounding cases,
      // half-saturated mean (half-up on the mean), both tags and marks.
      directed_px.push_back(make_pixel(1'b0, 0, 0, 0, 1'b1));        // black
      directed_px.push_back(make_pixel(1'b1, 255, 255, 255, 1'b1));  // white, gray
      directed_px.push_back(make_pixel(1'b0, 255, 0, 0, 1'b1));      // full red
      directed_px.push_back(make_pixel(1'b1, 0, 255, 0, 1'b0));
      directed_px.push_back(make_pixel(1'b1, 0, 0, 255, 1'b0));
      directed_px.push_back(make_pixel(1'b1, 1, 0, 0, 1'b1));        // smallest max
      directed_px.push_back(make_pixel(1'b0, 255, 254, 0, 1'b0));
      directed_px.push_back(make_pixel(1'b0, 128, 128, 127, 1'b0));
      directed_px.push_back(make_pixel(1'b0, 1, 1, 1, 1'b0));
      directed_px.push_back(make_pixel(1'b0, 0, 0, 0, 1'b1));        // black inside image
      directed_px.push_back(make_pixel(1'b1, 3, 2, 2, 1'b1));        // ratio rounding
      directed_px.push_back(make_pixel(1'b0, 255, 0, 0, 1'b0));
      directed_px.push_back(make_pixel(1'b0, 0, 0, 0, 1'b1));        // mean exactly .5
      directed_px.push_back(make_pixel(1'b1, 200, 100, 50, 1'b0));
      directed_px.push_back(make_pixel(1'b1, 17, 34, 51, 1'b0));
      directed_px.push_back(make_pixel(1'b1, 85, 170, 255, 1'b1));
      directed_px.push_back(make_pixel(1'b0, 254, 255, 1, 1'b1));
      directed_px.push_back(make_pixel(1'b1, 0, 255, 255, 1'b1));

      // Hold reset, then release it at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part back to back.
      foreach (directed_px[i]) send_pixel(directed_px[i]);

      // Random images: mostly short, some long; sender bursts with gaps,
      // with stretches where it never idles.
      sent       = 0;
      burst_left = 0;
      eager      = 1'b0;
      while (sent < PIXEL_GOAL) begin
         case ($urandom_range(0, 9))
            0:       img_len = 1;
            1, 2:    img_len = $urandom_range(7, 30);
            default: img_len = $urandom_range(1, 6);
         endcase
         if ($urandom_range(0, 19) == 0) eager = !eager;
         p.tag = 1'($urandom_range(0, 1));
         for (int k = 0; k < img_len; k++) begin
            if (burst_left == 0) begin
               if (!eager) idle_req($urandom_range(0, 15));
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            p.red   = PIX_BITS'(rand_chan());
            p.green = PIX_BITS'(rand_chan());
            p.blue  = PIX_BITS'(rand_chan());
            p.last  = (k == img_len - 1);
            send_pixel(p);
            sent++;
         end
      end
      idle_req(1);

      // Drain, then let the block settle for a final result window.
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (sb.errors == 0) begin
         $display("mean_hsv_saturation_tb OK");
      end else begin
         $display("mean_hsv_saturation_tb NOT OK");
      end
      $finish;
   end

endmodule
